// ----- hdl/dzpb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the deadband PID balance block.
`default_nettype none

package dzpb_pkg;

  localparam int unsigned AXES    = 3;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned DB_W    = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned DIFF_W  = ERR_W + 1;
  localparam int unsigned INT_W   = 24;
  localparam int unsigned ADJ_W   = 10;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned FRAC_W  = 12;

  localparam int unsigned PROD_P_W = GAIN_W + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + INT_W;
  localparam int unsigned PROD_D_W = GAIN_W + DIFF_W;
  localparam int unsigned SUM_W    = PROD_I_W + 2;
  localparam int unsigned RND_W    = SUM_W - FRAC_W;

  localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic signed [ADJ_W-1:0] ADJ_MAX = 10'sd480;
  localparam logic signed [ADJ_W-1:0] ADJ_MIN = -10'sd480;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_DEAD_BAND = 2'd0;
  localparam cfg_index_t CFG_GAIN_P    = 2'd1;
  localparam cfg_index_t CFG_GAIN_I    = 2'd2;
  localparam cfg_index_t CFG_GAIN_D    = 2'd3;

  // per-axis controller terms after the state update
  typedef struct packed {
    logic signed [ERR_W-1:0]  u;
    logic signed [INT_W-1:0]  isum;
    logic signed [DIFF_W-1:0] d;
  } axis_terms_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] p;
    logic signed [PROD_I_W-1:0] i;
    logic signed [PROD_D_W-1:0] d;
  } axis_prod_t;

  // zero inside the band, band removed from the magnitude outside it
  function automatic logic signed [ERR_W-1:0] deadband(input logic signed [ERR_W-1:0] e,
                                                       input logic [DB_W-1:0] db);
    logic signed [ERR_W-1:0] dbs;
    dbs = $signed({{(ERR_W-DB_W){1'b0}}, db});
    if (e > dbs) begin
      return e - dbs;
    end else if (e < -dbs) begin
      return e + dbs;
    end else begin
      return '0;
    end
  endfunction

  function automatic logic signed [INT_W-1:0] sat_add(input logic signed [INT_W-1:0] acc,
                                                      input logic signed [ERR_W-1:0] u);
    logic signed [INT_W:0] s;
    s = (INT_W+1)'(acc) + (INT_W+1)'(u);
    if (s > (INT_W+1)'(INT_MAX)) begin
      return INT_MAX;
    end else if (s < (INT_W+1)'(INT_MIN)) begin
      return INT_MIN;
    end else begin
      return s[INT_W-1:0];
    end
  endfunction

  // round to nearest (ties up) from Q.12, then clamp to +-30 mm
  function automatic logic signed [ADJ_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sr;
    logic signed [RND_W-1:0] r;
    sr = s + ROUND_HALF;
    r  = sr[SUM_W-1:FRAC_W];
    if (r > RND_W'(ADJ_MAX)) begin
      return ADJ_MAX;
    end else if (r < RND_W'(ADJ_MIN)) begin
      return ADJ_MIN;
    end else begin
      return r[ADJ_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/deadzone_pid_balance.sv -----
// Three-axis deadband PID balance controller, top level.
// Usage:
//   Input channel (in_valid/in_stall): one word per control tick, carrying the
//   frame number, requested and measured centre of mass (1/16 mm, signed).
//   Output channel (out_valid/out_stall): one word per input word, carrying
//   the hip adjustments adj_x/y/z, clamped to +-480 (1/16 mm).
//   Config port: cfg_we/cfg_index/cfg_data writes dead_band (0), gain_p (1),
//   gain_i (2), gain_d (3); write only while the block is empty.
// Path: the input word is captured in the input register, then
// deadband/integrator/multiply-add/round/clamp feed the result register,
// which raises out_valid.
// Throughput: one word per cycle while out_stall is low; the integrator/derivative
// update is a loop between the input register and the history registers.
// Reset (rst, synchronous): empties both registers, clears gains, band,
// integrators, previous errors, last frame and the first-step flag.
// Stall: the result register holds while out_stall is high; one more word
// can wait in the input register, after that in_stall rises.
`default_nettype none

module deadzone_pid_balance (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  dzpb_pkg::cfg_index_t      cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               frame_number,
  input  logic signed [15:0]        req_x,
  input  logic signed [15:0]        req_y,
  input  logic signed [15:0]        req_z,
  input  logic signed [15:0]        meas_x,
  input  logic signed [15:0]        meas_y,
  input  logic signed [15:0]        meas_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [9:0]         adj_x,
  output logic signed [9:0]         adj_y,
  output logic signed [9:0]         adj_z
);

  // configuration
  logic [dzpb_pkg::DB_W-1:0]          dead_band;
  logic signed [dzpb_pkg::GAIN_W-1:0] gain_p;
  logic signed [dzpb_pkg::GAIN_W-1:0] gain_i;
  logic signed [dzpb_pkg::GAIN_W-1:0] gain_d;

  // controller history
  logic signed [dzpb_pkg::ERR_W-1:0]  prev_err [dzpb_pkg::AXES];
  logic signed [dzpb_pkg::INT_W-1:0]  integ    [dzpb_pkg::AXES];
  logic [dzpb_pkg::FRAME_W-1:0]       last_frame;
  logic                               has_run;

  // input and result registers
  logic                               s0_valid;
  logic [dzpb_pkg::FRAME_W-1:0]       s0_frame;
  logic signed [dzpb_pkg::POS_W-1:0]  s0_req  [dzpb_pkg::AXES];
  logic signed [dzpb_pkg::POS_W-1:0]  s0_meas [dzpb_pkg::AXES];
  logic signed [dzpb_pkg::ADJ_W-1:0]  adj     [dzpb_pkg::AXES];

  dzpb_pkg::axis_terms_t              terms_next [dzpb_pkg::AXES];
  logic signed [dzpb_pkg::ADJ_W-1:0]  adj_next   [dzpb_pkg::AXES];

  logic out_en, s0_en, accept, step;
  logic skip;
  logic [dzpb_pkg::FRAME_W-1:0] frame_inc;

  assign out_en   = !out_valid || !out_stall;
  assign s0_en    = !s0_valid || out_en;
  assign in_stall = !s0_en;
  assign accept   = in_valid && s0_en;
  assign step     = s0_valid && out_en;

  assign adj_x = adj[0];
  assign adj_y = adj[1];
  assign adj_z = adj[2];

  // skipped frame: compare against last + 1, wrapping at 32 bits
  assign frame_inc = last_frame + dzpb_pkg::FRAME_W'(1);
  assign skip      = has_run && (s0_frame > frame_inc);

  always_comb begin
    logic signed [dzpb_pkg::ERR_W-1:0]  e;
    logic signed [dzpb_pkg::ERR_W-1:0]  u;
    logic signed [dzpb_pkg::ERR_W-1:0]  prev_use;
    logic signed [dzpb_pkg::INT_W-1:0]  int_use;
    logic signed [dzpb_pkg::INT_W-1:0]  isum;
    logic signed [dzpb_pkg::DIFF_W-1:0] d;
    dzpb_pkg::axis_prod_t               prod;
    logic signed [dzpb_pkg::SUM_W-1:0]  sum;
    for (int k = 0; k < dzpb_pkg::AXES; k++) begin
      e        = dzpb_pkg::ERR_W'(s0_req[k]) - dzpb_pkg::ERR_W'(s0_meas[k]);
      u        = dzpb_pkg::deadband(e, dead_band);
      prev_use = skip ? '0 : prev_err[k];
      int_use  = skip ? '0 : integ[k];
      isum     = dzpb_pkg::sat_add(int_use, u);
      d        = dzpb_pkg::DIFF_W'(u) - dzpb_pkg::DIFF_W'(prev_use);
      terms_next[k].u    = u;
      terms_next[k].isum = isum;
      terms_next[k].d    = d;
      prod.p = dzpb_pkg::PROD_P_W'(gain_p) * dzpb_pkg::PROD_P_W'(u);
      prod.i = dzpb_pkg::PROD_I_W'(gain_i) * dzpb_pkg::PROD_I_W'(isum);
      prod.d = dzpb_pkg::PROD_D_W'(gain_d) * dzpb_pkg::PROD_D_W'(d);
      sum = dzpb_pkg::SUM_W'(prod.p) + dzpb_pkg::SUM_W'(prod.i)
          + dzpb_pkg::SUM_W'(prod.d);
      adj_next[k] = dzpb_pkg::round_clamp(sum);
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      out_valid  <= 1'b0;
      dead_band  <= '0;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      last_frame <= '0;
      has_run    <= 1'b0;
      for (int k = 0; k < dzpb_pkg::AXES; k++) begin
        prev_err[k] <= '0;
        integ[k]    <= '0;
      end
    end else begin
      if (s0_en) s0_valid <= in_valid;
      if (out_en) out_valid <= s0_valid;
      if (step) begin
        last_frame <= s0_frame;
        has_run    <= 1'b1;
        for (int k = 0; k < dzpb_pkg::AXES; k++) begin
          prev_err[k] <= terms_next[k].u;
          integ[k]    <= terms_next[k].isum;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          dzpb_pkg::CFG_DEAD_BAND: dead_band <= cfg_data[dzpb_pkg::DB_W-1:0];
          dzpb_pkg::CFG_GAIN_P:    gain_p    <= $signed(cfg_data);
          dzpb_pkg::CFG_GAIN_I:    gain_i    <= $signed(cfg_data);
          dzpb_pkg::CFG_GAIN_D:    gain_d    <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_frame   <= frame_number;
      s0_req[0]  <= req_x;
      s0_req[1]  <= req_y;
      s0_req[2]  <= req_z;
      s0_meas[0] <= meas_x;
      s0_meas[1] <= meas_y;
      s0_meas[2] <= meas_z;
    end
    if (step) adj <= adj_next;
  end

endmodule

`default_nettype wire

// ----- hdl/dzpb_checker.sv -----
// Port-level checks for the deadband PID balance block, bound to its top level.
`default_nettype none

module dzpb_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [9:0] adj_x,
  input logic signed [9:0] adj_y,
  input logic signed [9:0] adj_z
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(adj_x) && $stable(adj_y) && $stable(adj_z))
    else $error("output word changed while stalled");

  // results always lie within +-30 mm
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> adj_x <= dzpb_pkg::ADJ_MAX && adj_x >= dzpb_pkg::ADJ_MIN
               && adj_y <= dzpb_pkg::ADJ_MAX && adj_y >= dzpb_pkg::ADJ_MIN
               && adj_z <= dzpb_pkg::ADJ_MAX && adj_z >= dzpb_pkg::ADJ_MIN)
    else $error("adjustment out of range");

  // with an empty output register every stage advances, so input is never held
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind deadzone_pid_balance dzpb_checker u_dzpb_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the deadband PID balance block: scoreboard, drivers and run control.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_WORDS = 110;
  localparam int DRAIN_PAD   = 8;     // extra wait past the two-register path
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int SAT_HI      = 2 ** (dzpb_pkg::INT_W - 1) - 1;
  localparam int SAT_LO      = -(2 ** (dzpb_pkg::INT_W - 1));
  localparam int ADJ_LIM     = 480;

  typedef logic [dzpb_pkg::AXES-1:0][dzpb_pkg::POS_W-1:0] pos3_t;
  typedef logic [dzpb_pkg::AXES-1:0][dzpb_pkg::ADJ_W-1:0] adj3_t;

  class adj_scoreboard;
    logic [dzpb_pkg::DB_W-1:0]          band;
    logic signed [dzpb_pkg::GAIN_W-1:0] kp, ki, kd;
    logic signed [dzpb_pkg::ERR_W-1:0]  last_err [dzpb_pkg::AXES];
    logic signed [dzpb_pkg::INT_W-1:0]  accum [dzpb_pkg::AXES];
    logic [dzpb_pkg::FRAME_W-1:0]       last_frame;
    bit                                 started;
    adj3_t                              adj_due [$];
    int unsigned                        n_in, n_out, n_bad, n_skip, n_clip;

    function new();
      band = '0;
      kp = '0;
      ki = '0;
      kd = '0;
      for (int k = 0; k < dzpb_pkg::AXES; k++) begin
        last_err[k] = '0;
        accum[k] = '0;
      end
      last_frame = '0;
      started = 1'b0;
    endfunction

    function void set_reg(dzpb_pkg::cfg_index_t idx, logic [dzpb_pkg::CFG_W-1:0] data);
      case (idx)
        dzpb_pkg::CFG_DEAD_BAND: band = data[dzpb_pkg::DB_W-1:0];
        dzpb_pkg::CFG_GAIN_P:    kp = data;
        dzpb_pkg::CFG_GAIN_I:    ki = data;
        dzpb_pkg::CFG_GAIN_D:    kd = data;
        default: ;
      endcase
    endfunction

    // advance the controller state by one input word and queue the adjustment it gives
    function void note_tick(logic [dzpb_pkg::FRAME_W-1:0] frame, pos3_t req, pos3_t meas);
      logic [dzpb_pkg::FRAME_W-1:0] next_frame;
      adj3_t adj;
      int e, u, acc, db;
      longint s, r;
      next_frame = last_frame + 1;
      if (started && frame > next_frame) begin
        n_skip++;
        for (int k = 0; k < dzpb_pkg::AXES; k++) begin
          last_err[k] = '0;
          accum[k] = '0;
        end
      end
      db = int'(band);
      for (int k = 0; k < dzpb_pkg::AXES; k++) begin
        e = $signed(req[k]) - $signed(meas[k]);
        if (e > db) begin
          u = e - db;
        end else if (e < -db) begin
          u = e + db;
        end else begin
          u = 0;
        end
        acc = accum[k] + u;
        if (acc > SAT_HI) begin
          acc = SAT_HI;
          n_clip++;
        end else if (acc < SAT_LO) begin
          acc = SAT_LO;
          n_clip++;
        end
        s = longint'(kp) * u + longint'(ki) * acc + longint'(kd) * (u - last_err[k]);
        r = (s + 2048) >>> dzpb_pkg::FRAC_W;  // floor, so ties go up
        if (r > ADJ_LIM) r = ADJ_LIM;
        if (r < -ADJ_LIM) r = -ADJ_LIM;
        adj[k] = r[dzpb_pkg::ADJ_W-1:0];
        accum[k] = acc[dzpb_pkg::INT_W-1:0];
        last_err[k] = u[dzpb_pkg::ERR_W-1:0];
      end
      last_frame = frame;
      started = 1'b1;
      adj_due.push_back(adj);
      n_in++;
    endfunction

    function void check_adj(adj3_t got);
      adj3_t want;
      n_out++;
      if (adj_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result word %0d arrived with nothing expected", n_out);
        return;
      end
      want = adj_due.pop_front();
      for (int k = 0; k < dzpb_pkg::AXES; k++) begin
        if (got[k] !== want[k]) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("word %0d adj_%c: expected %0d, got %0d", n_out, 8'(120 + k),
                     $signed(want[k]), $signed(got[k]));
          end
        end
      end
    endfunction

    function int pending();
      return adj_due.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  dzpb_pkg::cfg_index_t       cfg_index = dzpb_pkg::CFG_DEAD_BAND;
  logic [dzpb_pkg::CFG_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [31:0]                frame_number = '0;
  logic signed [15:0]         req_x = '0, req_y = '0, req_z = '0;
  logic signed [15:0]         meas_x = '0, meas_y = '0, meas_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [9:0]          adj_x, adj_y, adj_z;

  adj_scoreboard sb;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_len = 0;
  int quiet = 0;

  deadzone_pid_balance u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .frame_number(frame_number),
    .req_x(req_x), .req_y(req_y), .req_z(req_z),
    .meas_x(meas_x), .meas_y(meas_y), .meas_z(meas_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .adj_x(adj_x), .adj_y(adj_y), .adj_z(adj_z)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else if (rst || rx_pct == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (in_valid && !in_stall) begin
        sb.note_tick(frame_number, {req_z, req_y, req_x}, {meas_z, meas_y, meas_x});
      end
      if (out_valid && !out_stall) begin
        sb.check_adj({adj_z, adj_y, adj_x});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d words outstanding", quiet, sb.pending());
        $display("** deadzone_pid_balance: FAILED **");
        $finish;
      end
    end
  end

  function automatic pos3_t xyz(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
    return {z, y, x};
  endfunction

  task automatic send(logic [31:0] f, pos3_t req, pos3_t meas);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_number <= f;
    req_x <= req[0];
    req_y <= req[1];
    req_z <= req[2];
    meas_x <= meas[0];
    meas_y <= meas[1];
    meas_z <= meas[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic load_gains(logic [dzpb_pkg::CFG_W-1:0] db, logic [dzpb_pkg::CFG_W-1:0] gp,
                            logic [dzpb_pkg::CFG_W-1:0] gi, logic [dzpb_pkg::CFG_W-1:0] gd);
    dzpb_pkg::cfg_index_t regs [4];
    logic [dzpb_pkg::CFG_W-1:0] vals [4];
    regs = '{dzpb_pkg::CFG_DEAD_BAND, dzpb_pkg::CFG_GAIN_P, dzpb_pkg::CFG_GAIN_I,
             dzpb_pkg::CFG_GAIN_D};
    vals = '{db, gp, gi, gd};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n, seq_len, err_style, frame_mode, pick, off, lo, hi, w, m;
    bit sgn, first_seq;
    logic [31:0] fr;
    pos3_t req, meas;

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first step, band edges, repeated/earlier/skipped frames, wrap, extremes
    load_gains(16'd100, 16'd4096, 16'd16, -16'sd2048);
    send(32'd5, xyz(0, 0, 0), xyz(0, 0, 0));
    send(32'd6, xyz(100, -100, 0), xyz(0, 0, 0));
    send(32'd7, xyz(101, -101, 99), xyz(0, 0, 0));
    send(32'd7, xyz(0, 0, 0), xyz(101, -101, -1));
    send(32'd2, xyz(1000, -1000, 500), xyz(0, 0, 0));
    send(32'd9, xyz(500, 0, -500), xyz(0, -500, 0));
    send(32'd10, xyz(32767, -32768, 32767), xyz(-32768, 32767, 32767));
    send(32'd11, xyz(-32768, 32767, -32768), xyz(-32768, 32767, -32768));
    send(32'd12, xyz(32767, -32768, 0), xyz(-32768, 32767, 0));
    send(32'hFFFF_FFFF, xyz(300, -300, 150), xyz(0, 0, 0));
    send(32'h0000_0000, xyz(300, -300, 150), xyz(0, 0, 0));
    send(32'h0000_0001, xyz(-200, 200, 0), xyz(0, 0, 0));
    send(32'hFFFF_FFFE, xyz(400, 400, -400), xyz(0, 0, 0));
    send(32'hFFFF_FFFF, xyz(0, 0, 0), xyz(0, 0, 0));
    drain();
    load_gains(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    send(32'd100, xyz(32767, 0, 0), xyz(0, 0, 0));
    send(32'd101, xyz(32767, -32767, 32767), xyz(0, 0, -1));
    send(32'd102, xyz(32767, -32768, -32768), xyz(-32768, 32767, 0));
    send(32'd103, xyz(0, 0, 0), xyz(0, 0, 0));
    send(32'd104, xyz(-32768, 32767, 32767), xyz(32767, -32768, -32768));
    fr = 32'd104;

    // random phases, each with its own register setting and one of four idle patterns
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 47; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 47; end
        default: begin tx_pct = 17; rx_pct = 17; end
      endcase
      case (p)
        0: load_gains(16'd0, 16'd4096, 16'd64, 16'd1024);
        1: load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: load_gains(16'($urandom_range(0, 200)), 16'h8000, 16'h8000, 16'h8000);
        4: load_gains(16'($urandom_range(0, 50)), 16'($urandom_range(0, 16383) - 8192),
                      16'($urandom_range(0, 511) - 256),
                      16'($urandom_range(0, 16383) - 8192));
        5: load_gains(16'd0, 16'd0, 16'd0, 16'd0);
        6: load_gains(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 8191) - 4096),
                      16'($urandom_range(0, 511) - 256),
                      16'($urandom_range(0, 8191) - 4096));
        default: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      // long receiver hold-off while words keep coming, so the block backs up
      if (p == 0 || p == 4) hold_len = 90;

      n = 0;
      first_seq = 1'b1;
      while (n < PHASE_WORDS) begin
        pick = $urandom_range(99);
        sgn = 1'($urandom_range(1));
        if ((first_seq && (p == 0 || p == 4)) || pick < 10) begin
          // long run of large same-sign errors drives the integrator into its rails
          frame_mode = 0;
          err_style = 2;
          seq_len = $urandom_range(150, 220);
          if (first_seq) sgn = (p == 0);
        end else if (pick < 70) begin
          frame_mode = 0;
          err_style = $urandom_range(0, 1);
          seq_len = $urandom_range(4, 60);
        end else if (pick < 90) begin
          frame_mode = 1;
          err_style = $urandom_range(0, 3);
          seq_len = $urandom_range(2, 30);
        end else begin
          frame_mode = 2;
          err_style = 3;
          seq_len = $urandom_range(1, 10);
        end
        if (frame_mode == 0 && $urandom_range(1)) fr = $urandom;

        for (int i = 0; i < seq_len; i++) begin
          case (frame_mode)
            0: fr = fr + 1;
            1: begin
              case ($urandom_range(9))
                5: ;
                6: fr = fr - $urandom_range(1, 50);
                7: fr = fr + $urandom_range(2, 1000);
                8: fr = $urandom;
                default: fr = fr + 1;
              endcase
            end
            default: fr = $urandom;
          endcase
          for (int k = 0; k < dzpb_pkg::AXES; k++) begin
            if (err_style == 3) begin
              req[k] = 16'($urandom);
              meas[k] = 16'($urandom);
            end else begin
              case (err_style)
                0: begin
                  w = int'(sb.band) + 300;
                  off = int'($urandom_range(0, 2 * w)) - w;
                end
                1: begin
                  off = $urandom_range(1) ? int'(sb.band) : -int'(sb.band);
                  off = off + int'($urandom_range(0, 2)) - 1;
                end
                default: begin
                  off = $urandom_range(45000, 65535);
                  if (!sgn) off = -off;
                end
              endcase
              lo = (off > 0) ? -32768 : -32768 - off;
              hi = (off > 0) ? 32767 - off : 32767;
              m = lo + int'($urandom_range(0, hi - lo));
              meas[k] = m[15:0];
              m = m + off;
              req[k] = m[15:0];
            end
          end
          send(fr, req, meas);
          n++;
        end
        // now and then the sender waits for every outstanding word
        if ($urandom_range(9) == 0 || (p == 1 && first_seq)) drain();
        first_seq = 1'b0;
      end
    end

    drain();
    $display("%0d input words and %0d result words over ten register settings and four idle mixes",
             sb.n_in, sb.n_out);
    $display("%0d history clears on skipped frames, %0d integrator clips, %0d mismatches",
             sb.n_skip, sb.n_clip, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("** deadzone_pid_balance: PASSED **");
    end else begin
      $display("** deadzone_pid_balance: FAILED **");
    end
    $finish;
  end

endmodule
